/* hw/rtl/icacf_pkg.sv */
// ----------------------------------------------------------------------------
// icacf_pkg
// Shared constants and types for the ICA contrast function evaluator.
// ----------------------------------------------------------------------------
package icacf_pkg;

  localparam logic [63:0] Q60_ONE = 64'd1 << 60;
  localparam int SERIES_TERMS = 18;
  localparam int HALVINGS = 6;
  localparam int DIV_QW = 31;

  typedef enum logic [1:0] {
    MODE_LOGCOSH = 2'd0,
    MODE_GAUSS   = 2'd1,
    MODE_CUBE    = 2'd2,
    MODE_ABS     = 2'd3
  } mode_t;

  // Control and sample data that travel with each word down the pipeline.
  typedef struct packed {
    logic        vld;
    mode_t       mode;
    logic        neg;
    logic [15:0] mag;
  } side_t;

endpackage

/* hw/rtl/icacf_mul.sv */
// ----------------------------------------------------------------------------
// icacf_mul
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
// ----------------------------------------------------------------------------
module icacf_mul (
  input  logic         clk,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] p
);

  logic [63:0] ll;
  logic [63:0] lh;
  logic [63:0] hl;
  logic [63:0] hh;

  always_ff @(posedge clk) begin
    ll <= 64'(a[31:0]) * 64'(b[31:0]);
    lh <= 64'(a[31:0]) * 64'(b[63:32]);
    hl <= 64'(a[63:32]) * 64'(b[31:0]);
    hh <= 64'(a[63:32]) * 64'(b[63:32]);
  end

  always_ff @(posedge clk) begin
    p <= {64'd0, ll} + {32'd0, lh, 32'd0} + {32'd0, hl, 32'd0} + {hh, 64'd0};
  end

endmodule

/* hw/rtl/icacf_exp.sv */
// ----------------------------------------------------------------------------
// icacf_exp
// Pipelined e^-x in Q60: Horner series of e^-(x/64), then six squarings.
// ----------------------------------------------------------------------------
module icacf_exp import icacf_pkg::*; #(
  parameter int NTERMS = SERIES_TERMS,
  parameter int NSQ    = HALVINGS
) (
  input  logic        clk,
  input  logic        rst,
  input  side_t       sb_in,
  input  logic [63:0] y_in,
  output side_t       sb_out,
  output logic [63:0] e_out
);

  logic [63:0] p_t [NTERMS];
  logic [63:0] y_t [NTERMS];
  side_t       s_t [NTERMS];
  logic [63:0] p_s [NSQ];
  side_t       s_s [NSQ];

  for (genvar j = 0; j < NTERMS; j++) begin : g_term
    localparam logic [63:0] K = 64'(NTERMS - j);
    localparam logic [63:0] RECIP = 64'hFFFF_FFFF_FFFF_FFFF / K;

    logic [63:0]  p_i;
    logic [63:0]  y_i;
    side_t        s_i;
    logic [127:0] prod_yp;
    logic [127:0] prod_mr;
    logic [63:0]  m;
    logic [63:0]  q_est;
    logic [63:0]  rem;
    logic [63:0]  p_r;
    logic [63:0]  m_d [2];
    logic [63:0]  y_d [5];
    side_t        s_d [5];

    if (j == 0) begin : g_head
      assign p_i = Q60_ONE;
      assign y_i = y_in;
      assign s_i = sb_in;
    end else begin : g_link
      assign p_i = p_t[j-1];
      assign y_i = y_t[j-1];
      assign s_i = s_t[j-1];
    end

    icacf_mul u_mul_yp (.clk(clk), .a(y_i), .b(p_i), .p(prod_yp));

    assign m = {4'd0, prod_yp[119:60]};

    // Division by the term index: reciprocal estimate, low by at most one.
    icacf_mul u_mul_mr (.clk(clk), .a(m), .b(RECIP), .p(prod_mr));

    assign q_est = prod_mr[127:64];
    assign rem   = m_d[1] - 64'(q_est * K);

    always_ff @(posedge clk) begin
      m_d[0] <= m;
      m_d[1] <= m_d[0];
      y_d[0] <= y_i;
      for (int k = 1; k < 5; k++) y_d[k] <= y_d[k-1];
      p_r <= Q60_ONE - (q_est + {63'd0, rem >= K});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        for (int k = 0; k < 5; k++) s_d[k] <= '0;
      end else begin
        s_d[0] <= s_i;
        for (int k = 1; k < 5; k++) s_d[k] <= s_d[k-1];
      end
    end

    assign p_t[j] = p_r;
    assign y_t[j] = y_d[4];
    assign s_t[j] = s_d[4];
  end

  for (genvar i = 0; i < NSQ; i++) begin : g_sq
    logic [63:0]  p_i;
    side_t        s_i;
    logic [127:0] prod;
    side_t        s_d [2];

    if (i == 0) begin : g_head
      assign p_i = p_t[NTERMS-1];
      assign s_i = s_t[NTERMS-1];
    end else begin : g_link
      assign p_i = p_s[i-1];
      assign s_i = s_s[i-1];
    end

    icacf_mul u_mul_sq (.clk(clk), .a(p_i), .b(p_i), .p(prod));

    always_ff @(posedge clk) begin
      if (rst) begin
        s_d[0] <= '0;
        s_d[1] <= '0;
      end else begin
        s_d[0] <= s_i;
        s_d[1] <= s_d[0];
      end
    end

    assign p_s[i] = {3'd0, prod[120:60]};
    assign s_s[i] = s_d[1];
  end

  assign e_out  = p_s[NSQ-1];
  assign sb_out = s_s[NSQ-1];

endmodule

/* hw/rtl/icacf_div.sv */
// ----------------------------------------------------------------------------
// icacf_div
// Pipelined restoring divider, one quotient bit per stage, with NL numerator
// lanes sharing one divisor and a payload that rides along.
// ----------------------------------------------------------------------------
module icacf_div #(
  parameter int NL = 1,
  parameter int QW = 31,
  parameter int PW = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   vld_in,
  input  logic [NL-1:0][63:0]    num_in,
  input  logic [63:0]            den_in,
  input  logic [PW-1:0]          pay_in,
  output logic                   vld_out,
  output logic [NL-1:0][QW-1:0]  quo_out,
  output logic [PW-1:0]          pay_out
);

  logic                  vld_c [QW];
  logic [NL-1:0][63:0]   rem_c [QW];
  logic [NL-1:0][QW-1:0] quo_c [QW];
  logic [63:0]           den_c [QW];
  logic [PW-1:0]         pay_c [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int SH = QW - 1 - i;

    logic                  vld_i;
    logic [NL-1:0][63:0]   rem_i;
    logic [NL-1:0][QW-1:0] quo_i;
    logic [63:0]           den_i;
    logic [PW-1:0]         pay_i;
    logic [63:0]           dsh;
    logic                  vld_r;
    logic [NL-1:0][63:0]   rem_r;
    logic [NL-1:0][QW-1:0] quo_r;
    logic [63:0]           den_r;
    logic [PW-1:0]         pay_r;

    if (i == 0) begin : g_head
      assign vld_i = vld_in;
      assign rem_i = num_in;
      assign quo_i = '0;
      assign den_i = den_in;
      assign pay_i = pay_in;
    end else begin : g_link
      assign vld_i = vld_c[i-1];
      assign rem_i = rem_c[i-1];
      assign quo_i = quo_c[i-1];
      assign den_i = den_c[i-1];
      assign pay_i = pay_c[i-1];
    end

    assign dsh = den_i << SH;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      den_r <= den_i;
      pay_r <= pay_i;
      for (int l = 0; l < NL; l++) begin
        if (rem_i[l] >= dsh) begin
          rem_r[l] <= rem_i[l] - dsh;
          quo_r[l] <= {quo_i[l][QW-2:0], 1'b1};
        end else begin
          rem_r[l] <= rem_i[l];
          quo_r[l] <= {quo_i[l][QW-2:0], 1'b0};
        end
      end
    end

    assign vld_c[i] = vld_r;
    assign rem_c[i] = rem_r;
    assign quo_c[i] = quo_r;
    assign den_c[i] = den_r;
    assign pay_c[i] = pay_r;
  end

  assign vld_out = vld_c[QW-1];
  assign quo_out = quo_c[QW-1];
  assign pay_out = pay_c[QW-1];

endmodule

/* hw/rtl/ica_contrast_function_eval_top.sv */
// ----------------------------------------------------------------------------
// ica_contrast_function_eval_top
// FastICA contrast function g(u) and derivative g'(u), Q4.12 in, Q11.20 out.
// ----------------------------------------------------------------------------
// Usage: drive sample and pulse start; a word is taken on every edge with
// start high, since busy is always low and the pipeline takes one word per
// cycle, back to back. cfg_we with cfg_data selects the contrast function
// (logcosh, gaussian, cube, abs); write it only while no word is in flight.
// Each word moves through the pipeline with the mode it was taken under.
// Output: done pulses for one cycle, with g_value and g_derivative, as the
// word leaves the pipeline, whose length is set by the exponential (18 Horner
// terms of five stages, six squarings of two stages) and two 31-stage
// divisions used by logcosh; every mode has the same latency, so results
// leave in order. Throughput is one word per cycle.
// Reset clears the mode to logcosh and all valid bits; words in flight are
// dropped. The receiver has no stall, so results are never held.
// ----------------------------------------------------------------------------
module ica_contrast_function_eval_top import icacf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_data,
  input  logic signed [15:0] sample,
  output logic               done,
  output logic signed [31:0] g_value,
  output logic signed [31:0] g_derivative
);

  typedef struct packed {
    side_t       sb;
    logic [31:0] g;
    logic [31:0] gd;
    logic [63:0] den;
  } d1_pay_t;

  typedef struct packed {
    side_t             sb;
    logic [31:0]       g;
    logic [31:0]       gd;
    logic [DIV_QW-1:0] t;
  } d2_pay_t;

  function automatic logic [31:0] apply_sign(input logic neg, input logic [31:0] m);
    return neg ? (~m + 32'd1) : m;
  endfunction

  mode_t       mode_q;
  side_t       s0;
  side_t       s1;
  logic [31:0] sq0;
  logic [63:0] y1;
  side_t       s_e;
  logic [63:0] e_e;

  side_t       s_p1;
  logic [31:0] sq_p1;
  logic [32:0] e32g_p1;
  logic [63:0] den_p1;
  logic [63:0] nt_p1;
  logic [63:0] n1_p1;
  logic [63:0] e32;
  logic [63:0] e32g;
  logic [63:0] den;
  logic [63:0] num;

  side_t       s_p2;
  logic [63:0] prod_g1;
  logic [63:0] prod_d1;
  logic [63:0] cube;
  logic [33:0] sq3;
  logic        dneg_p2;
  logic [63:0] den_p2;
  logic [63:0] nt_p2;
  logic [63:0] n1_p2;
  logic        dneg;
  logic [31:0] dm;

  side_t       s_p3;
  logic [31:0] g_p3;
  logic [31:0] gd_p3;
  logic [63:0] den_p3;
  logic [63:0] nt_p3;
  logic [63:0] n1_p3;
  logic [31:0] g_alt;
  logic [31:0] gd_alt;

  d1_pay_t                   d1_in;
  d1_pay_t                   d1_out;
  logic                      d1_vld;
  logic [1:0][DIV_QW-1:0]    d1_quo;
  d2_pay_t                   d2_in;
  d2_pay_t                   d2_out;
  logic                      d2_vld;
  logic [0:0][DIV_QW-1:0]    d2_quo;
  logic [33:0]               gd_lc;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q <= MODE_LOGCOSH;
    end else if (cfg_we) begin
      mode_q <= mode_t'(cfg_data);
    end
  end

  // Input capture and exponent argument.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0 <= '0;
    end else begin
      s0.vld  <= start;
      s0.mode <= mode_q;
      s0.neg  <= sample[15];
      s0.mag  <= sample[15] ? 16'(-sample) : 16'(sample);
    end
  end

  assign sq0 = 32'(s0.mag) * 32'(s0.mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else begin
      s1 <= s0;
    end
  end

  always_ff @(posedge clk) begin
    case (s0.mode)
      MODE_LOGCOSH: y1 <= {5'd0, s0.mag, 43'd0};
      MODE_GAUSS:   y1 <= {3'd0, sq0, 29'd0};
      default:      y1 <= 64'd0;
    endcase
  end

  icacf_exp #(
    .NTERMS(SERIES_TERMS),
    .NSQ   (HALVINGS)
  ) u_exp (
    .clk   (clk),
    .rst   (rst),
    .sb_in (s1),
    .y_in  (y1),
    .sb_out(s_e),
    .e_out (e_e)
  );

  // Post stage 1: rescale the exponential, square the magnitude and set up the logcosh divisions.
  assign e32  = e_e >> 28;
  assign e32g = (e_e + (64'd1 << 27)) >> 28;
  assign den  = (64'd1 << 32) + e32;
  assign num  = (Q60_ONE - e_e) >> 28;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_p1 <= '0;
    end else begin
      s_p1 <= s_e;
    end
  end

  always_ff @(posedge clk) begin
    sq_p1   <= 32'(s_e.mag) * 32'(s_e.mag);
    e32g_p1 <= e32g[32:0];
    den_p1  <= den;
    nt_p1   <= (num << 20) + (den >> 1);
    n1_p1   <= e32 << 30;
  end

  // Post stage 2: products for the gaussian and cube pairs.
  assign dneg = sq_p1 > (32'd1 << 24);
  assign dm   = dneg ? (sq_p1 - (32'd1 << 24)) : ((32'd1 << 24) - sq_p1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s_p2 <= '0;
    end else begin
      s_p2 <= s_p1;
    end
  end

  always_ff @(posedge clk) begin
    prod_g1 <= 64'(s_p1.mag) * 64'(e32g_p1);
    prod_d1 <= 64'(dm) * 64'(e32g_p1);
    cube    <= 64'(sq_p1) * 64'(s_p1.mag);
    sq3     <= 34'(sq_p1) * 34'd3 + 34'd8;
    dneg_p2 <= dneg;
    den_p2  <= den_p1;
    nt_p2   <= nt_p1;
    n1_p2   <= n1_p1;
  end

  // Post stage 3: rounding and sign for every mode but logcosh.
  always_comb begin
    case (s_p2.mode)
      MODE_GAUSS: begin
        g_alt  = apply_sign(s_p2.neg, 32'((prod_g1 + (64'd1 << 23)) >> 24));
        gd_alt = apply_sign(dneg_p2, 32'((prod_d1 + (64'd1 << 35)) >> 36));
      end
      MODE_CUBE: begin
        g_alt  = apply_sign(s_p2.neg, 32'((cube + (64'd1 << 15)) >> 16));
        gd_alt = 32'(sq3 >> 4);
      end
      MODE_ABS: begin
        g_alt  = {8'd0, s_p2.mag, 8'd0};
        gd_alt = (s_p2.mag == 16'd0) ? 32'd0 : apply_sign(s_p2.neg, 32'd1 << 20);
      end
      default: begin
        g_alt  = 32'd0;
        gd_alt = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_p3 <= '0;
    end else begin
      s_p3 <= s_p2;
    end
  end

  always_ff @(posedge clk) begin
    g_p3   <= g_alt;
    gd_p3  <= gd_alt;
    den_p3 <= den_p2;
    nt_p3  <= nt_p2;
    n1_p3  <= n1_p2;
  end

  // Logcosh: tanh magnitude and the first quotient of 4E/(1+E)^2 together.
  assign d1_in.sb  = s_p3;
  assign d1_in.g   = g_p3;
  assign d1_in.gd  = gd_p3;
  assign d1_in.den = den_p3;

  icacf_div #(
    .NL(2),
    .QW(DIV_QW),
    .PW($bits(d1_pay_t))
  ) u_div_first (
    .clk    (clk),
    .rst    (rst),
    .vld_in (s_p3.vld),
    .num_in ({n1_p3, nt_p3}),
    .den_in (den_p3),
    .pay_in (d1_in),
    .vld_out(d1_vld),
    .quo_out(d1_quo),
    .pay_out(d1_out)
  );

  assign d2_in.sb = d1_out.sb;
  assign d2_in.g  = d1_out.g;
  assign d2_in.gd = d1_out.gd;
  assign d2_in.t  = d1_quo[0];

  icacf_div #(
    .NL(1),
    .QW(DIV_QW),
    .PW($bits(d2_pay_t))
  ) u_div_second (
    .clk    (clk),
    .rst    (rst),
    .vld_in (d1_vld),
    .num_in ({1'b0, d1_quo[1], 32'd0}),
    .den_in (d1_out.den),
    .pay_in (d2_in),
    .vld_out(d2_vld),
    .quo_out(d2_quo),
    .pay_out(d2_out)
  );

  assign gd_lc = ({1'b0, d2_quo[0], 2'b00} + 34'd512) >> 10;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (d2_out.sb.mode == MODE_LOGCOSH) begin
      g_value      <= apply_sign(d2_out.sb.neg, 32'(d2_out.t));
      g_derivative <= 32'(gd_lc);
    end else begin
      g_value      <= d2_out.g;
      g_derivative <= d2_out.gd;
    end
  end

endmodule
